/* src/mi3_pkg.sv */
// ----------------------------------------------------------------------------
// mi3_pkg
// types and constants shared by the 3x3 matrix inverse pipeline
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int EW  = 32;        // element width
    localparam int CW  = 64;        // cofactor width
    localparam int DW  = 96;        // determinant magnitude width
    localparam int SW  = 98;        // determinant sum width
    localparam int QW  = 32;        // quotient bits
    localparam int NEL = 9;         // elements per matrix

    typedef struct packed {
        logic signed [EW-1:0] a_r0c0;
        logic signed [EW-1:0] a_r0c1;
        logic signed [EW-1:0] a_r0c2;
        logic signed [EW-1:0] a_r1c0;
        logic signed [EW-1:0] a_r1c1;
        logic signed [EW-1:0] a_r1c2;
        logic signed [EW-1:0] a_r2c0;
        logic signed [EW-1:0] a_r2c1;
        logic signed [EW-1:0] a_r2c2;
    } mat_t;

    typedef struct packed {
        logic signed [EW-1:0] inv_r0c0;
        logic signed [EW-1:0] inv_r0c1;
        logic signed [EW-1:0] inv_r0c2;
        logic signed [EW-1:0] inv_r1c0;
        logic signed [EW-1:0] inv_r1c1;
        logic signed [EW-1:0] inv_r1c2;
        logic signed [EW-1:0] inv_r2c0;
        logic signed [EW-1:0] inv_r2c1;
        logic signed [EW-1:0] inv_r2c2;
        logic                 singular;
    } res_t;

    // element 0 is row 0 column 0, row-major
    typedef logic [0:NEL-1][EW-1:0] elems_t;
    typedef logic [0:NEL-1][CW-1:0] cofs_t;

    typedef struct packed {
        logic          zero;
        logic          neg;
        logic [DW-1:0] mag;
    } det_t;

    // cofactor i = a[A1]*a[B1] - a[A2]*a[B2]
    localparam int unsigned COF_A1 [NEL] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
    localparam int unsigned COF_B1 [NEL] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
    localparam int unsigned COF_A2 [NEL] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
    localparam int unsigned COF_B2 [NEL] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

endpackage

/* src/matrix3_inverse.sv */
// ----------------------------------------------------------------------------
// matrix3_inverse
// 3x3 signed fixed-point matrix inverse by adjugate over determinant
// throughput: one transaction per cycle, busy is never raised
// the depth is set by the 32-stage restoring divider in each of nine lanes
// reset clears only the valid pipeline; payload registers are not reset
// ----------------------------------------------------------------------------
module matrix3_inverse
    import mi3_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  mat_t matrix,
    output logic busy,
    output logic done,
    output res_t result
);

    // stage budget
    localparam int LAT_COF  = 2;
    localparam int LAT_DET  = 4;
    localparam int LAT_LANE = QW + 3;
    localparam int PIPE     = 1 + LAT_COF + LAT_DET + LAT_LANE;
    localparam int DONE_LAT = PIPE + 1;

    elems_t                mx_reg  [PIPE];
    cofs_t                 cd_reg  [LAT_DET];
    logic [PIPE-1:0]       vld_reg;
    logic [LAT_LANE-1:0]   sing_reg;
    cofs_t                 cof;
    det_t                  det;
    logic [0:NEL-1][EW-1:0] lane_q;
    elems_t                inv_next;
    res_t                  result_reg;
    logic                  done_reg;

    // pipeline never stalls, receiver cannot hold off
    assign busy = 1'b0;

    // matrix delay line: feeds the cofactors, the determinant and the singular bypass
    always_ff @(posedge clk)
    begin
        mx_reg[0] <= elems_t'(matrix);
        for (int k = 1; k < PIPE; k++)
        begin
            mx_reg[k] <= mx_reg[k-1];
        end
    end

    // transaction valid tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[PIPE-2:0], start & ~busy};
            done_reg <= vld_reg[PIPE-1];
        end
    end

    // cofactors
    mi3_cof u_cof
    (
        .clk (clk),
        .a   (mx_reg[0]),
        .c   (cof)
    );

    // determinant from the first row and the matching cofactors
    mi3_det u_det
    (
        .clk (clk),
        .a   (mx_reg[LAT_COF]),
        .c   (cof),
        .det (det)
    );

    // hold cofactors until the determinant is ready
    always_ff @(posedge clk)
    begin
        cd_reg[0] <= cof;
        for (int k = 1; k < LAT_DET; k++)
        begin
            cd_reg[k] <= cd_reg[k-1];
        end
        sing_reg <= {sing_reg[LAT_LANE-2:0], det.zero};
    end

    // nine divider lanes, one per adjugate entry
    for (genvar i = 0; i < NEL; i++)
    begin : g_lane
        mi3_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane
        (
            .clk (clk),
            .cof (cd_reg[LAT_DET-1][i]),
            .det (det),
            .q   (lane_q[i])
        );
    end

    // merge: singular matrix passes through unchanged
    always_comb
    begin
        for (int i = 0; i < NEL; i++)
        begin
            inv_next[i] = sing_reg[LAT_LANE-1] ? mx_reg[PIPE-1][i] : lane_q[i];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= res_t'({inv_next, sing_reg[LAT_LANE-1]});
    end

    assign result = result_reg;
    assign done   = done_reg;

`ifndef SYNTHESIS
    // every accepted transaction gives exactly one result after the fixed latency
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##DONE_LAT done)
        else $error("missing result strobe");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##DONE_LAT !done)
        else $error("result strobe without transaction");

    // singular bypass returns the original matrix
    a_sing_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.singular) |->
            (result.inv_r0c0 == $past(matrix.a_r0c0, DONE_LAT)) &&
            (result.inv_r2c2 == $past(matrix.a_r2c2, DONE_LAT)))
        else $error("singular result does not match input");
`endif

endmodule

/* src/mi3_cof.sv */
// ----------------------------------------------------------------------------
// mi3_cof
// nine cofactors of the adjugate, two pipeline stages
// ----------------------------------------------------------------------------
module mi3_cof
    import mi3_pkg::*;
(
    input  logic   clk,
    input  elems_t a,
    output cofs_t  c
);

    logic signed [CW-1:0] p1_reg [NEL];
    logic signed [CW-1:0] p2_reg [NEL];
    logic signed [CW-1:0] c_reg  [NEL];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NEL; i++)
        begin
            p1_reg[i] <= $signed(a[COF_A1[i]]) * $signed(a[COF_B1[i]]);
            p2_reg[i] <= $signed(a[COF_A2[i]]) * $signed(a[COF_B2[i]]);
            c_reg[i]  <= p1_reg[i] - p2_reg[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < NEL; i++)
        begin
            c[i] = c_reg[i];
        end
    end

endmodule

/* src/mi3_det.sv */
// ----------------------------------------------------------------------------
// mi3_det
// determinant by first-row expansion, magnitude and sign, four stages
// ----------------------------------------------------------------------------
module mi3_det
    import mi3_pkg::*;
(
    input  logic   clk,
    input  elems_t a,
    input  cofs_t  c,
    output det_t   det
);

    logic signed [CW-1:0] ph_reg   [3];
    logic signed [CW:0]   pl_reg   [3];
    logic        [DW-1:0] term_reg [3];
    logic        [SW-1:0] sum_reg;
    logic        [SW-1:0] sum_neg;
    det_t                 det_reg;

    assign sum_neg = '0 - sum_reg;

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            // split the 64-bit cofactor into a signed high and unsigned low half
            ph_reg[j] <= $signed(a[j]) * $signed(c[3*j][CW-1:EW]);
            pl_reg[j] <= $signed(a[j]) * $signed({1'b0, c[3*j][EW-1:0]});
            term_reg[j] <= {ph_reg[j], {EW{1'b0}}}
                         + {{(DW-CW-1){pl_reg[j][CW]}}, pl_reg[j]};
        end
        sum_reg <= {{(SW-DW){term_reg[0][DW-1]}}, term_reg[0]}
                 + {{(SW-DW){term_reg[1][DW-1]}}, term_reg[1]}
                 + {{(SW-DW){term_reg[2][DW-1]}}, term_reg[2]};
        det_reg.zero <= (sum_reg == '0);
        det_reg.neg  <= sum_reg[SW-1];
        det_reg.mag  <= sum_reg[SW-1] ? sum_neg[DW-1:0] : sum_reg[DW-1:0];
    end

    assign det = det_reg;

endmodule

/* src/mi3_lane.sv */
// ----------------------------------------------------------------------------
// mi3_lane
// one divider lane: cof * 2^(2F) / det, restoring, one quotient bit a stage
// ----------------------------------------------------------------------------
module mi3_lane
    import mi3_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic          clk,
    input  logic [CW-1:0] cof,
    input  det_t          det,
    output logic [EW-1:0] q
);

    localparam int NW = CW + 2*FRAC_BITS;
    localparam int HW = NW - QW;

    logic          neg1_reg;
    logic [CW-1:0] mag1_reg;
    logic [DW-1:0] d1_reg;
    logic [NW-1:0] num;
    logic [HW-1:0] num_hi;

    logic [DW-1:0] rem_reg [QW+1];
    logic [QW-1:0] low_reg [QW+1];
    logic [QW-1:0] quo_reg [QW+1];
    logic [DW-1:0] d_reg   [QW+1];
    logic          neg_reg [QW+1];
    logic          ovf_reg [QW+1];
    logic [EW-1:0] q_reg;

    assign num    = {mag1_reg, {(2*FRAC_BITS){1'b0}}};
    assign num_hi = num[NW-1:QW];

    always_ff @(posedge clk)
    begin
        neg1_reg <= cof[CW-1] ^ det.neg;
        mag1_reg <= cof[CW-1] ? (CW'(0) - cof) : cof;
        d1_reg   <= det.mag;
        // quotient of 2^32 or more saturates either way
        ovf_reg[0] <= (DW'(num_hi) >= d1_reg);
        rem_reg[0] <= DW'(num_hi);
        low_reg[0] <= num[QW-1:0];
        quo_reg[0] <= '0;
        d_reg[0]   <= d1_reg;
        neg_reg[0] <= neg1_reg;
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;

        assign trial = {rem_reg[k], low_reg[k][QW-1]};
        assign diff  = trial - {1'b0, d_reg[k]};
        assign ge    = (trial >= {1'b0, d_reg[k]});

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
            low_reg[k+1] <= {low_reg[k][QW-2:0], 1'b0};
            quo_reg[k+1] <= {quo_reg[k][QW-2:0], ge};
            d_reg[k+1]   <= d_reg[k];
            neg_reg[k+1] <= neg_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (neg_reg[QW])
        begin
            if (ovf_reg[QW] || (quo_reg[QW] > {1'b1, {(QW-1){1'b0}}}))
                q_reg <= {1'b1, {(EW-1){1'b0}}};
            else
                q_reg <= EW'(0) - quo_reg[QW];
        end
        else
        begin
            if (ovf_reg[QW] || quo_reg[QW][QW-1])
                q_reg <= {1'b0, {(EW-1){1'b1}}};
            else
                q_reg <= quo_reg[QW];
        end
    end

    assign q = q_reg;

endmodule
